### sv/sspq_pkg.sv
// ---------------------------------------------------------------------------
// sspq_pkg: shared types and constants
// Sizes, word layouts and codes of the stable sorted priority queue.
// ---------------------------------------------------------------------------
package sspq_pkg;

  localparam int DEPTH         = 16;
  localparam int PRIO_WIDTH    = 8;
  localparam int PAYLOAD_WIDTH = 32;
  localparam int CNT_W         = $clog2(DEPTH + 1);

  localparam logic ACT_INSERT = 1'b0;
  localparam logic ACT_REMOVE = 1'b1;

  typedef enum logic [1:0] {
    STATUS_OK    = 2'd0,
    STATUS_EMPTY = 2'd1,
    STATUS_FULL  = 2'd2
  } status_t;

  typedef struct packed {
    logic [PRIO_WIDTH-1:0]    prio;
    logic [PAYLOAD_WIDTH-1:0] data;
  } entry_t;

  typedef struct packed {
    logic                     action;
    logic [PRIO_WIDTH-1:0]    priority_req;
    logic [PAYLOAD_WIDTH-1:0] payload;
  } req_t;

  typedef struct packed {
    status_t                  status;
    logic [PAYLOAD_WIDTH-1:0] out_payload;
    logic [PRIO_WIDTH-1:0]    out_priority;
    logic [CNT_W-1:0]         occupancy;
  } rsp_t;

  // broadcast to every cell in the chain
  typedef struct packed {
    logic   ins;
    logic   rem;
    entry_t new_entry;
  } cell_ctrl_t;

endpackage

### sv/stable_sorted_priority_queue.sv
// ---------------------------------------------------------------------------
// stable_sorted_priority_queue: bounded sorted priority queue
// Shift-register queue of DEPTH cells, kept in ascending priority order.
// ---------------------------------------------------------------------------
// Usage:
//   req channel (req_valid/req_ready/req) carries one operation word: insert
//   a payload with a priority, or remove the head entry.
//   rsp channel (rsp_valid/rsp_ready/rsp) returns one word per operation:
//   status, the removed entry (zero otherwise) and the occupancy after it.
//   Every cell compares the new priority against its own in the same cycle
//   and shifts by one slot, so an operation finishes in the cycle it is
//   accepted; its response word is registered and shows in the next cycle.
//   Throughput is one operation per cycle while rsp_ready stays high.
//   A new operation is taken when the response register is empty or is being
//   read in the same cycle, so a stalled receiver holds back req_ready after
//   one word is waiting.
//   Equal priorities leave in arrival order. Insert into a full queue returns
//   the full status, remove from an empty queue the empty status, and neither
//   changes the contents.
//   Reset empties the queue and the response register; the entry slots are
//   not cleared, only the entry count.
// ---------------------------------------------------------------------------
module stable_sorted_priority_queue (
  input  logic           clk,
  input  logic           rst,
  input  logic           req_valid,
  output logic           req_ready,
  input  sspq_pkg::req_t req,
  output logic           rsp_valid,
  input  logic           rsp_ready,
  output sspq_pkg::rsp_t rsp
);
  import sspq_pkg::*;

  logic [CNT_W-1:0] count;
  logic [CNT_W-1:0] count_next;
  logic             accept;
  logic             full;
  logic             empty;
  cell_ctrl_t       ctrl;
  rsp_t             rsp_next;

  logic   [DEPTH-1:0] cell_valid;
  logic   [DEPTH-1:0] cell_gt;
  entry_t             cell_entry [DEPTH];

  assign req_ready = !rsp_valid || rsp_ready;
  assign accept    = req_valid && req_ready;
  assign full      = (count == CNT_W'(DEPTH));
  assign empty     = (count == '0);

  assign ctrl.ins            = accept && (req.action == ACT_INSERT) && !full;
  assign ctrl.rem            = accept && (req.action == ACT_REMOVE) && !empty;
  assign ctrl.new_entry.prio = req.priority_req;
  assign ctrl.new_entry.data = req.payload;

  genvar i;
  generate
    for (i = 0; i < DEPTH; i++) begin : g_cell
      assign cell_valid[i] = (count > CNT_W'(i));
      if (i == 0) begin : g_head
        sspq_cell u_cell (
          .clk        (clk),
          .ctrl       (ctrl),
          .valid      (cell_valid[i]),
          .left_gt    (1'b0),
          .left_entry ('0),
          .right_entry(cell_entry[i+1]),
          .gt         (cell_gt[i]),
          .entry      (cell_entry[i])
        );
      end else if (i == DEPTH - 1) begin : g_tail
        sspq_cell u_cell (
          .clk        (clk),
          .ctrl       (ctrl),
          .valid      (cell_valid[i]),
          .left_gt    (cell_gt[i-1]),
          .left_entry (cell_entry[i-1]),
          .right_entry('0),
          .gt         (cell_gt[i]),
          .entry      (cell_entry[i])
        );
      end else begin : g_mid
        sspq_cell u_cell (
          .clk        (clk),
          .ctrl       (ctrl),
          .valid      (cell_valid[i]),
          .left_gt    (cell_gt[i-1]),
          .left_entry (cell_entry[i-1]),
          .right_entry(cell_entry[i+1]),
          .gt         (cell_gt[i]),
          .entry      (cell_entry[i])
        );
      end
    end
  endgenerate

  always_comb begin
    count_next = count;
    if (ctrl.ins) begin
      count_next = count + CNT_W'(1);
    end else if (ctrl.rem) begin
      count_next = count - CNT_W'(1);
    end
  end

  always_comb begin
    rsp_next              = '0;
    rsp_next.status       = STATUS_OK;
    rsp_next.occupancy    = count_next;
    if (req.action == ACT_REMOVE) begin
      if (empty) begin
        rsp_next.status = STATUS_EMPTY;
      end else begin
        rsp_next.out_payload  = cell_entry[0].data;
        rsp_next.out_priority = cell_entry[0].prio;
      end
    end else if (full) begin
      rsp_next.status = STATUS_FULL;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count     <= '0;
      rsp_valid <= 1'b0;
    end else begin
      count <= count_next;
      if (accept) begin
        rsp_valid <= 1'b1;
      end else if (rsp_ready) begin
        rsp_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      rsp <= rsp_next;
    end
  end

endmodule

### sv/sspq_cell.sv
// ---------------------------------------------------------------------------
// sspq_cell: one slot of the sorted chain
// Holds one entry; on insert it keeps, takes the new entry or takes its left
// neighbor, on remove it takes its right neighbor.
// ---------------------------------------------------------------------------
module sspq_cell (
  input  logic                clk,
  input  sspq_pkg::cell_ctrl_t ctrl,
  input  logic                valid,
  input  logic                left_gt,
  input  sspq_pkg::entry_t    left_entry,
  input  sspq_pkg::entry_t    right_entry,
  output logic                gt,
  output sspq_pkg::entry_t    entry
);
  import sspq_pkg::*;

  entry_t entry_next;

  // strictly greater keeps equal priorities in arrival order
  assign gt = valid && (entry.prio > ctrl.new_entry.prio);

  always_comb begin
    entry_next = entry;
    if (ctrl.rem) begin
      entry_next = right_entry;
    end else if (ctrl.ins) begin
      if (left_gt) begin
        entry_next = left_entry;
      end else if (gt || !valid) begin
        // empty slots past the insertion point may take it too, harmless
        entry_next = ctrl.new_entry;
      end
    end
  end

  always_ff @(posedge clk) begin
    entry <= entry_next;
  end

endmodule

### verif/sspq_checker.sv
// ---------------------------------------------------------------------------
// sspq_checker: response checker for the stable sorted priority queue
// Watches both channels, keeps its own sorted copy of the queue, predicts
// the response word of each accepted operation and compares field by field.
// ---------------------------------------------------------------------------
module sspq_checker (
  input  logic           clk,
  input  logic           rst,
  input  logic           req_valid,
  input  logic           req_ready,
  input  sspq_pkg::req_t req,
  input  logic           rsp_valid,
  input  logic           rsp_ready,
  input  sspq_pkg::rsp_t rsp,
  output int             mismatch_count,
  output int             outstanding
);
  import sspq_pkg::*;

  localparam int REPORT_LIMIT = 10;

  logic [PRIO_WIDTH-1:0]    held_prio [DEPTH];
  logic [PAYLOAD_WIDTH-1:0] held_data [DEPTH];
  int                       held_count;
  rsp_t                     predicted_rsp [$];

  initial begin
    mismatch_count = 0;
    outstanding    = 0;
    held_count     = 0;
  end

  // updates the copy of the queue and returns the response it should give
  function automatic rsp_t apply_queue_op(input req_t op);
    rsp_t r;
    int   slot;
    int   i;
    r        = '0;
    r.status = STATUS_OK;
    if (op.action == ACT_INSERT) begin
      if (held_count >= DEPTH) begin
        r.status = STATUS_FULL;
      end else begin
        // new entry goes behind every entry of equal or lower value
        slot = 0;
        while (slot < held_count && held_prio[slot] <= op.priority_req) slot++;
        for (i = held_count; i > slot; i--) begin
          held_prio[i] = held_prio[i-1];
          held_data[i] = held_data[i-1];
        end
        held_prio[slot] = op.priority_req;
        held_data[slot] = op.payload;
        held_count++;
      end
    end else begin
      if (held_count == 0) begin
        r.status = STATUS_EMPTY;
      end else begin
        r.out_priority = held_prio[0];
        r.out_payload  = held_data[0];
        for (i = 1; i < held_count; i++) begin
          held_prio[i-1] = held_prio[i];
          held_data[i-1] = held_data[i];
        end
        held_count--;
      end
    end
    r.occupancy = held_count[CNT_W-1:0];
    return r;
  endfunction

  task automatic note_mismatch(input string what, input rsp_t exp_w, input rsp_t got_w);
    mismatch_count++;
    if (mismatch_count <= REPORT_LIMIT) begin
      $display("mismatch (%s): expected status %0d payload %h prio %0d occ %0d",
               what, exp_w.status, exp_w.out_payload, exp_w.out_priority, exp_w.occupancy);
      $display("  got status %0d payload %h prio %0d occ %0d",
               got_w.status, got_w.out_payload, got_w.out_priority, got_w.occupancy);
    end
  endtask

  always @(posedge clk) begin
    rsp_t exp_w;
    if (rst) begin
      held_count = 0;
      predicted_rsp.delete();
    end else begin
      if (rsp_valid && rsp_ready) begin
        if (predicted_rsp.size() == 0) begin
          note_mismatch("unexpected word", '0, rsp);
        end else begin
          exp_w = predicted_rsp.pop_front();
          if (rsp.status !== exp_w.status)             note_mismatch("status", exp_w, rsp);
          else if (rsp.out_payload !== exp_w.out_payload)   note_mismatch("payload", exp_w, rsp);
          else if (rsp.out_priority !== exp_w.out_priority) note_mismatch("priority", exp_w, rsp);
          else if (rsp.occupancy !== exp_w.occupancy)       note_mismatch("occupancy", exp_w, rsp);
        end
      end
      if (req_valid && req_ready) predicted_rsp.push_back(apply_queue_op(req));
    end
    outstanding = predicted_rsp.size();
  end

endmodule

### verif/testbench.sv
// ---------------------------------------------------------------------------
// testbench: top level for the stable sorted priority queue
// Drives directed and random insert/remove words in bursts while the
// receiver stalls on its own pattern; the checker judges every response.
// ---------------------------------------------------------------------------
module testbench;
  import sspq_pkg::*;

  localparam int RANDOM_OPS  = 1000;
  localparam int CYCLE_LIMIT = 200000;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic req_valid;
  logic req_ready;
  req_t req_word;
  logic rsp_valid;
  logic rsp_ready;
  rsp_t rsp_word;

  int mismatch_count;
  int outstanding;
  int cycle_count = 0;
  int burst_left  = 1;
  int rx_tick     = 0;

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  stable_sorted_priority_queue u_top (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_ready (req_ready),
    .req       (req_word),
    .rsp_valid (rsp_valid),
    .rsp_ready (rsp_ready),
    .rsp       (rsp_word)
  );

  sspq_checker u_checker (
    .clk            (clk),
    .rst            (rst),
    .req_valid      (req_valid),
    .req_ready      (req_ready),
    .req            (req_word),
    .rsp_valid      (rsp_valid),
    .rsp_ready      (rsp_ready),
    .rsp            (rsp_word),
    .mismatch_count (mismatch_count),
    .outstanding    (outstanding)
  );

  // receiver: always ready, random, mostly stalled, rarely stalled
  always @(posedge clk) begin
    case ((rx_tick / 150) % 4)
      0:       rsp_ready <= 1'b1;
      1:       rsp_ready <= 1'($urandom_range(1, 0));
      2:       rsp_ready <= (rx_tick % 5 == 0);
      default: rsp_ready <= ($urandom_range(9, 0) != 0);
    endcase
    rx_tick++;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  // holds the word until accepted, then maybe opens a gap between bursts
  task automatic send_op(input logic act, input logic [PRIO_WIDTH-1:0] prio,
                         input logic [PAYLOAD_WIDTH-1:0] data);
    req_t w;
    int   gap;
    w.action       = act;
    w.priority_req = prio;
    w.payload      = data;
    req_word  <= w;
    req_valid <= 1'b1;
    do @(posedge clk); while (!req_ready);
    burst_left--;
    if (burst_left <= 0) begin
      burst_left = $urandom_range(40, 1);
      gap        = $urandom_range(6, 1);
      req_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  initial begin
    int                       insert_pct;
    int                       sel;
    logic                     act;
    logic [PRIO_WIDTH-1:0]    prio;
    logic [PAYLOAD_WIDTH-1:0] data;

    req_valid <= 1'b0;
    req_word  <= '0;
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed: empty remove, fill with extremes and ties, full insert, drain a few
    send_op(ACT_REMOVE, 8'h5a, 32'h1234_5678);
    send_op(ACT_INSERT, 8'd255, 32'hffff_ffff);
    send_op(ACT_INSERT, 8'd0,   32'h0000_0000);
    send_op(ACT_INSERT, 8'd0,   32'h0000_0001);
    send_op(ACT_INSERT, 8'd128, 32'haaaa_5555);
    send_op(ACT_INSERT, 8'd128, 32'h5555_aaaa);
    send_op(ACT_INSERT, 8'd1,   32'h0000_0002);
    send_op(ACT_INSERT, 8'd254, 32'h8000_0000);
    send_op(ACT_INSERT, 8'd0,   32'h0000_0003);
    send_op(ACT_INSERT, 8'd255, 32'h7fff_ffff);
    send_op(ACT_INSERT, 8'd7,   32'h0000_0007);
    send_op(ACT_INSERT, 8'd7,   32'h0000_0008);
    send_op(ACT_INSERT, 8'd7,   32'h0000_0009);
    send_op(ACT_INSERT, 8'd3,   32'h0f0f_0f0f);
    send_op(ACT_INSERT, 8'd200, 32'hf0f0_f0f0);
    send_op(ACT_INSERT, 8'd0,   32'h0000_0004);
    send_op(ACT_INSERT, 8'd64,  32'hcafe_f00d);
    send_op(ACT_INSERT, 8'd9,   32'hdead_beef);
    send_op(ACT_REMOVE, 8'hff,  32'hffff_ffff);
    send_op(ACT_REMOVE, 8'h00,  32'h0000_0000);
    send_op(ACT_REMOVE, 8'h80,  32'h8000_0001);
    send_op(ACT_REMOVE, 8'h01,  32'h0000_0000);

    // random: insert share changes every 40 words so the queue swings full and empty
    insert_pct = 50;
    for (int n = 0; n < RANDOM_OPS; n++) begin
      if (n % 40 == 0) begin
        case ($urandom_range(3, 0))
          0:       insert_pct = 15;
          1:       insert_pct = 50;
          2:       insert_pct = 70;
          default: insert_pct = 90;
        endcase
      end
      act = ($urandom_range(99, 0) < insert_pct) ? ACT_INSERT : ACT_REMOVE;
      sel = $urandom_range(9, 0);
      if (sel < 5)       prio = PRIO_WIDTH'($urandom_range(3, 0));  // crowd of ties
      else if (sel == 5) prio = '0;
      else if (sel == 6) prio = '1;
      else               prio = PRIO_WIDTH'($urandom_range(255, 0));
      sel = $urandom_range(15, 0);
      if (sel == 0)      data = '0;
      else if (sel == 1) data = '1;
      else               data = $urandom();
      send_op(act, prio, data);
    end
    req_valid <= 1'b0;

    repeat (2) @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    if (mismatch_count == 0 && outstanding == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
